// File: rtl/lcbc_pkg.sv
// shared types and constants of the line comment and blank cleaner
`timescale 1ns / 1ps

package lcbc_pkg;

   // character codes
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   // space counter width, covers the largest allowed saturation limit of 63
   localparam int SPACE_CNT_W = 6;

   // command queue between front and back
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

   // one command: up to two text bytes, each after a run of spaces, then an optional marker
   typedef struct packed {
      logic                   has_a;
      logic [SPACE_CNT_W-1:0] spaces_a;
      logic [7:0]             byte_a;
      logic                   has_b;
      logic [SPACE_CNT_W-1:0] spaces_b;
      logic [7:0]             byte_b;
      logic                   eol;
   } cmd_type;

endpackage

// File: rtl/lcbc_req_if.sv
// input channel: one raw byte per transaction
`timescale 1ns / 1ps

interface lcbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: rtl/lcbc_rsp_if.sv
// result channel: one cleaned byte or end marker per transaction
`timescale 1ns / 1ps

interface lcbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       end_of_line;

   modport source (output valid, output out_byte, output has_byte, output end_of_line,
                   input ready);
   modport sink   (input valid, input out_byte, input has_byte, input end_of_line,
                   output ready);
endinterface

// File: rtl/lcbc_front.sv
// front part: scans bytes with one byte look-ahead and builds output commands
`timescale 1ns / 1ps

module lcbc_front import lcbc_pkg::*; #(
   parameter int MAX_PENDING_SPACES = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       last_byte,
   output logic       cmd_valid,
   output cmd_type    cmd_data,
   input  logic       cmd_ready
);

   localparam logic [SPACE_CNT_W-1:0] PEND_MAX = SPACE_CNT_W'(MAX_PENDING_SPACES);

   typedef struct packed {
      logic                   skip;
      logic                   line_cmt;
      logic                   blk_cmt;
      logic                   text_seen;
      logic [SPACE_CNT_W-1:0] pend;
   } scan_type;

   typedef struct packed {
      scan_type               st;
      logic                   emit;
      logic [SPACE_CNT_W-1:0] spaces;
   } step_type;

   logic [7:0]  held_char_ff;
   logic        held_valid_ff;
   scan_type    scan_ff;
   scan_type    scan_in;
   step_type    step_a;
   step_type    step_b;
   logic        accept;

   // one byte of the scan, with its look-ahead byte
   function automatic step_type scan_byte(input scan_type s, input logic [7:0] c,
                                          input logic has_next, input logic [7:0] nx);
      step_type r;
      logic     ctrl;
      logic     grow;
      r        = '0;
      r.st     = s;
      ctrl     = (c < CH_SPACE) || (c == CH_DEL);
      grow     = 1'b0;
      if (s.skip) begin
         r.st.skip = 1'b0;
      end else if (!s.line_cmt && !s.blk_cmt) begin
         if (ctrl) begin
            grow = 1'b1;
         end else if (c == CH_SLASH && has_next && nx == CH_SLASH) begin
            r.st.line_cmt = 1'b1;
            r.st.skip     = 1'b1;
            grow          = 1'b1;
         end else if (c == CH_SLASH && has_next && nx == CH_STAR) begin
            r.st.blk_cmt = 1'b1;
            r.st.skip    = 1'b1;
            grow         = 1'b1;
         end else if (c == CH_SPACE) begin
            grow = 1'b1;
         end else begin
            r.emit         = 1'b1;
            r.spaces       = s.pend;
            r.st.pend      = '0;
            r.st.text_seen = 1'b1;
         end
      end else if (s.blk_cmt) begin
         if (c == CH_STAR && has_next && nx == CH_SLASH) begin
            r.st.blk_cmt = 1'b0;
            r.st.skip    = 1'b1;
         end
      end else if (c == CH_NL) begin
         r.st.line_cmt = 1'b0;
      end
      if (grow && s.text_seen && s.pend < PEND_MAX) begin
         r.st.pend = s.pend + 1'b1;
      end
      return r;
   endfunction

   assign in_ready = cmd_ready;
   assign accept   = in_valid && in_ready;

   // held byte against the new byte, then the new byte alone at line end
   always_comb begin
      if (held_valid_ff) begin
         step_a = scan_byte(scan_ff, held_char_ff, 1'b1, in_byte);
      end else begin
         step_a    = '0;
         step_a.st = scan_ff;
      end
      step_b = scan_byte(step_a.st, in_byte, 1'b0, 8'h00);
      if (!last_byte) begin
         step_b.emit = 1'b0;
      end
      scan_in = last_byte ? '0 : step_a.st;
   end

   // command toward the back part
   always_comb begin
      cmd_data.has_a    = step_a.emit;
      cmd_data.spaces_a = step_a.spaces;
      cmd_data.byte_a   = held_char_ff;
      cmd_data.has_b    = step_b.emit;
      cmd_data.spaces_b = step_b.spaces;
      cmd_data.byte_b   = in_byte;
      cmd_data.eol      = last_byte;
      cmd_valid         = accept && (step_a.emit || step_b.emit || last_byte);
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         scan_ff       <= '0;
      end else if (accept) begin
         held_valid_ff <= !last_byte;
         scan_ff       <= scan_in;
      end
   end

   // held byte payload
   always_ff @(posedge clock) begin
      if (accept) begin
         held_char_ff <= in_byte;
      end
   end

endmodule

// File: rtl/lcbc_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps

module lcbc_cmd_fifo import lcbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_data,
   output logic    rd_valid,
   output cmd_type rd_data,
   input  logic    rd_pop
);

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff;
   logic [CMD_PTR_W-1:0] rd_ptr_ff;
   logic [CMD_PTR_W:0]   count_ff;
   logic                 do_wr;
   logic                 do_rd;

   assign wr_ready = (count_ff != (CMD_PTR_W+1)'(CMD_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/lcbc_back.sv
// back part: expands commands into space, text and marker results
`timescale 1ns / 1ps

module lcbc_back import lcbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd_data,
   output logic       cmd_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       has_byte,
   output logic       end_of_line
);

   typedef enum logic [1:0] {
      STG_A,
      STG_B,
      STG_EOL
   } stage_type;

   stage_type              stage_ff;
   stage_type              stage_in;
   logic [SPACE_CNT_W-1:0] cnt_ff;
   logic [SPACE_CNT_W-1:0] cnt_in;
   logic                   valid_ff;
   logic [7:0]             byte_ff;
   logic                   has_ff;
   logic                   eol_ff;
   logic [7:0]             byte_in;
   logic                   has_in;
   logic                   eol_in;
   logic                   load;
   logic                   slot_a;
   logic                   slot_b;
   logic [SPACE_CNT_W-1:0] run;
   logic [7:0]             text;
   logic                   done;

   assign load = !valid_ff || out_ready;

   // pick the next result of the head command
   always_comb begin
      slot_a   = (stage_ff == STG_A) && cmd_data.has_a;
      slot_b   = !slot_a && (stage_ff != STG_EOL) && cmd_data.has_b;
      run      = slot_a ? cmd_data.spaces_a : cmd_data.spaces_b;
      text     = slot_a ? cmd_data.byte_a : cmd_data.byte_b;
      stage_in = stage_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      byte_in  = 8'h00;
      has_in   = 1'b0;
      eol_in   = 1'b0;
      if (slot_a || slot_b) begin
         has_in = 1'b1;
         if (cnt_ff < run) begin
            byte_in = CH_SPACE;
            cnt_in  = cnt_ff + 1'b1;
         end else begin
            byte_in  = text;
            cnt_in   = '0;
            stage_in = slot_a ? STG_B : STG_EOL;
            done     = slot_a ? (!cmd_data.has_b && !cmd_data.eol) : !cmd_data.eol;
         end
      end else begin
         eol_in = 1'b1;
         done   = 1'b1;
      end
      if (done) begin
         stage_in = STG_A;
         cnt_in   = '0;
      end
   end

   assign cmd_pop = cmd_valid && load && done;

   // sequencing state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STG_A;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= cmd_valid;
         if (cmd_valid) begin
            stage_ff <= stage_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load && cmd_valid) begin
         byte_ff <= byte_in;
         has_ff  <= has_in;
         eol_ff  <= eol_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign has_byte    = has_ff;
   assign end_of_line = eol_ff;

endmodule

// File: rtl/line_comment_and_blank_cleaner.sv
// Line comment and blank cleaner, top level.
// req_chan carries one raw byte of a source line per transaction, with last_byte
// set on the final byte. rsp_chan carries the cleaned line: one byte per
// transaction (has_byte = 1), then a closing marker with end_of_line = 1.
// Comments are removed, leading blanks and control bytes dropped, inner blanks
// collapsed into held-back spaces (saturating at MAX_PENDING_SPACES) that
// are only sent before the next text byte, so trailing blanks disappear.
// A byte is scanned when its successor arrives (or the line ends); its results then
// pass through the command queue and the back part's output register.
// Input is taken one byte per cycle while the four-entry command queue has room.
// While the receiver is ready, the back part sends one result per cycle; one input
// byte may cause up to MAX_PENDING_SPACES + 3 results; the queue absorbs space bursts.
// When the receiver stalls, the output register holds its transaction, the queue
// fills, and then req_chan.ready drops. Synchronous reset clears line state,
// the queue and the output register; no clearing pass is needed.
`timescale 1ns / 1ps

module line_comment_and_blank_cleaner import lcbc_pkg::*; #(
   parameter int MAX_PENDING_SPACES = 31
) (
   input logic        clock,
   input logic        reset,
   lcbc_req_if.sink   req_chan,
   lcbc_rsp_if.source rsp_chan
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    head_valid;
   cmd_type head_data;
   logic    head_pop;

   // scanner
   lcbc_front #(
      .MAX_PENDING_SPACES(MAX_PENDING_SPACES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_byte   (req_chan.in_byte),
      .last_byte (req_chan.last_byte),
      .cmd_valid (push_valid),
      .cmd_data  (push_data),
      .cmd_ready (push_ready)
   );

   // command queue
   lcbc_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_data),
      .rd_valid (head_valid),
      .rd_data  (head_data),
      .rd_pop   (head_pop)
   );

   // result sequencer
   lcbc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd_data    (head_data),
      .cmd_pop     (head_pop),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_byte    (rsp_chan.out_byte),
      .has_byte    (rsp_chan.has_byte),
      .end_of_line (rsp_chan.end_of_line)
   );

endmodule
